/* hw/rtl/bdc_pkg.sv */
// ----------------------------------------------------------------------------
// bdc_pkg
// Types and constants shared by the button debounce / click / hold block.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned CntW     = 8;
  localparam int unsigned TotalW   = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgAddrW-1:0] {
    CfgIdleLevel     = 3'd0,
    CfgDebounceMs    = 3'd1,
    CfgMulticlickMs  = 3'd2,
    CfgHoldThreshMs  = 3'd3,
    CfgHoldRepeatMs  = 3'd4,
    CfgHoldListen    = 3'd5,
    CfgClickListen   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic           idle_level;
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] multiclick_ms;
    logic [MsW-1:0] hold_threshold_ms;
    logic [MsW-1:0] hold_repeat_ms;
    logic           hold_listen;
    logic           click_listen;
  } cfg_t;

  typedef struct packed {
    logic             sample;
    logic [TimeW-1:0] now_ms;
  } scan_t;

  typedef struct packed {
    logic              pressed;
    logic              changed;
    logic              press_event;
    logic              release_event;
    logic              hold_event;
    logic              click_event;
    logic [CntW-1:0]   click_count;
    logic [CntW-1:0]   hold_repeats;
    logic [TotalW-1:0] press_total;
    logic              hold_triggered;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/bdc_if.sv */
// ----------------------------------------------------------------------------
// bdc interfaces
// Valid/ready channels for scans, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdc_scan_if;
  logic                        valid;
  logic                        ready;
  logic                        sample;
  logic [bdc_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface bdc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        pressed;
  logic                        changed;
  logic                        press_event;
  logic                        release_event;
  logic                        hold_event;
  logic                        click_event;
  logic [bdc_pkg::CntW-1:0]    click_count;
  logic [bdc_pkg::CntW-1:0]    hold_repeats;
  logic [bdc_pkg::TotalW-1:0]  press_total;
  logic                        hold_triggered;

  modport source (
    output valid, output pressed, output changed, output press_event,
    output release_event, output hold_event, output click_event,
    output click_count, output hold_repeats, output press_total,
    output hold_triggered, input ready
  );
  modport sink (
    input valid, input pressed, input changed, input press_event,
    input release_event, input hold_event, input click_event,
    input click_count, input hold_repeats, input press_total,
    input hold_triggered, output ready
  );
endinterface

interface bdc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bdc_pkg::CfgAddrW-1:0]  index;
  logic [bdc_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bdc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bdc_cfg_regs
// Configuration register file, written through the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [bdc_pkg::CfgAddrW-1:0]  wr_index_i,
  input  wire logic [bdc_pkg::CfgDataW-1:0]  wr_data_i,
  output bdc_pkg::cfg_t                      cfg_o
);
  import bdc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CfgIdleLevel:    cfg_d.idle_level        = wr_data_i[0];
        CfgDebounceMs:   cfg_d.debounce_ms       = wr_data_i[MsW-1:0];
        CfgMulticlickMs: cfg_d.multiclick_ms     = wr_data_i[MsW-1:0];
        CfgHoldThreshMs: cfg_d.hold_threshold_ms = wr_data_i[MsW-1:0];
        CfgHoldRepeatMs: cfg_d.hold_repeat_ms    = wr_data_i[MsW-1:0];
        CfgHoldListen:   cfg_d.hold_listen       = wr_data_i[0];
        CfgClickListen:  cfg_d.click_listen      = wr_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_level        <= 1'b1;
      cfg_q.debounce_ms       <= MsW'(20);
      cfg_q.multiclick_ms     <= '0;
      cfg_q.hold_threshold_ms <= '0;
      cfg_q.hold_repeat_ms    <= '0;
      cfg_q.hold_listen       <= 1'b0;
      cfg_q.click_listen      <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/bdc_core.sv */
// ----------------------------------------------------------------------------
// bdc_core
// Debounce, click and hold state with the per-scan update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  bdc_pkg::cfg_t    cfg_i,
  input  wire logic        step_i,
  input  bdc_pkg::scan_t   scan_i,
  output bdc_pkg::result_t res_o
);
  import bdc_pkg::*;

  logic              last_raw_q, last_raw_d;
  logic              stable_q, stable_d;
  logic              click_sent_q, click_sent_d;
  logic              hold_fired_q, hold_fired_d;
  logic [TimeW-1:0]  bounce_q, bounce_d;
  logic [TimeW-1:0]  release_q, release_d;
  logic [TimeW-1:0]  press_start_q, press_start_d;
  logic [TimeW-1:0]  hold_last_q, hold_last_d;
  logic [CntW-1:0]   repeats_q, repeats_d;
  logic [CntW-1:0]   clicks_q, clicks_d;
  logic [TotalW-1:0] presses_q, presses_d;

  logic [TimeW-1:0]  now;
  logic              level;
  logic [TimeW-1:0]  since_bounce, since_release, since_hold, since_press;
  logic [TimeW-1:0]  since_release_d;
  logic              settled, due, in_window;
  logic              changed, press_ev, release_ev, hold_ev, click_ev;

  assign now = scan_i.now_ms;

  always_comb begin
    last_raw_d    = scan_i.sample;
    stable_d      = stable_q;
    click_sent_d  = click_sent_q;
    hold_fired_d  = hold_fired_q;
    release_d     = release_q;
    press_start_d = press_start_q;
    hold_last_d   = hold_last_q;
    repeats_d     = repeats_q;
    clicks_d      = clicks_q;
    presses_d     = presses_q;
    changed       = 1'b0;
    press_ev      = 1'b0;
    release_ev    = 1'b0;
    hold_ev       = 1'b0;
    click_ev      = 1'b0;

    bounce_d      = (scan_i.sample != last_raw_q) ? now : bounce_q;
    since_bounce  = now - bounce_d;
    since_release = now - release_q;
    since_hold    = now - hold_last_q;
    since_press   = now - press_start_q;
    settled       = since_bounce > TimeW'(cfg_i.debounce_ms);
    level         = scan_i.sample != cfg_i.idle_level;
    in_window     = since_release < TimeW'(cfg_i.multiclick_ms);
    due           = !hold_fired_q ||
                    ((cfg_i.hold_repeat_ms != '0) &&
                     (since_hold > TimeW'(cfg_i.hold_repeat_ms)));

    if (settled) begin
      if (level != stable_q) begin
        stable_d     = level;
        changed      = 1'b1;
        hold_fired_d = 1'b0;
        if (level) begin
          hold_last_d   = '0;
          repeats_d     = '0;
          presses_d     = presses_q + TotalW'(1);
          if (in_window) begin
            if (clicks_q != '1) begin
              clicks_d = clicks_q + CntW'(1);
            end
          end else begin
            clicks_d = CntW'(1);
          end
          press_ev      = 1'b1;
          press_start_d = now;
        end else begin
          release_ev   = 1'b1;
          release_d    = now;
          click_sent_d = 1'b0;
        end
      end else if (stable_q) begin
        if ((cfg_i.hold_threshold_ms != '0) && due &&
            (since_press > TimeW'(cfg_i.hold_threshold_ms)) && cfg_i.hold_listen) begin
          hold_ev      = 1'b1;
          hold_last_d  = now;
          if (repeats_q != '1) begin
            repeats_d = repeats_q + CntW'(1);
          end
          hold_fired_d = 1'b1;
        end
      end
    end

    since_release_d = now - release_d;
    if (cfg_i.click_listen && !click_sent_d && !stable_d &&
        ((cfg_i.multiclick_ms == '0) ||
         (since_release_d > TimeW'(cfg_i.multiclick_ms)))) begin
      click_ev     = 1'b1;
      click_sent_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      stable_q      <= 1'b0;
      click_sent_q  <= 1'b1;
      hold_fired_q  <= 1'b0;
      bounce_q      <= '0;
      release_q     <= '0;
      press_start_q <= '0;
      hold_last_q   <= '0;
      repeats_q     <= '0;
      clicks_q      <= '0;
      presses_q     <= '0;
    end else if (step_i) begin
      last_raw_q    <= last_raw_d;
      stable_q      <= stable_d;
      click_sent_q  <= click_sent_d;
      hold_fired_q  <= hold_fired_d;
      bounce_q      <= bounce_d;
      release_q     <= release_d;
      press_start_q <= press_start_d;
      hold_last_q   <= hold_last_d;
      repeats_q     <= repeats_d;
      clicks_q      <= clicks_d;
      presses_q     <= presses_d;
    end
  end

  always_comb begin
    res_o.pressed        = stable_d;
    res_o.changed        = changed;
    res_o.press_event    = press_ev;
    res_o.release_event  = release_ev;
    res_o.hold_event     = hold_ev;
    res_o.click_event    = click_ev;
    res_o.click_count    = clicks_d;
    res_o.hold_repeats   = repeats_d;
    res_o.press_total    = presses_d;
    res_o.hold_triggered = hold_fired_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/button_debounce_click_hold_top.sv */
// ----------------------------------------------------------------------------
// button_debounce_click_hold_top
// Button debouncer with multi-click counting and hold / hold-repeat events.
// ----------------------------------------------------------------------------
// scan words are registered in in_q, results in out_q once output is free
// throughput: one scan word per cycle unless result_o is stalled
// reset: asynchronous, active low; the click-sent flag and idle level start
// set, debounce starts at 20 ms, other state clears; data regs are not reset
`default_nettype none

module button_debounce_click_hold_top (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bdc_scan_if.sink      scan_i,
  bdc_cfg_if.sink       cfg_i,
  bdc_result_if.source  result_o
);
  import bdc_pkg::*;

  cfg_t    cfg;
  logic    in_valid_q;
  scan_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    advance;

  assign cfg_i.ready  = 1'b1;
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign scan_i.ready = !in_valid_q || advance;

  bdc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  bdc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .scan_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (scan_i.ready) begin
        in_valid_q <= scan_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_i.ready && scan_i.valid) begin
      in_q.sample <= scan_i.sample;
      in_q.now_ms <= scan_i.now_ms;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.pressed        = out_q.pressed;
  assign result_o.changed        = out_q.changed;
  assign result_o.press_event    = out_q.press_event;
  assign result_o.release_event  = out_q.release_event;
  assign result_o.hold_event     = out_q.hold_event;
  assign result_o.click_event    = out_q.click_event;
  assign result_o.click_count    = out_q.click_count;
  assign result_o.hold_repeats   = out_q.hold_repeats;
  assign result_o.press_total    = out_q.press_total;
  assign result_o.hold_triggered = out_q.hold_triggered;

endmodule

`default_nettype wire
